// ----- rtl/core/ebcs_pkg.sv -----
// package for the bus sequencer: payload types, phase codes, opcodes and flag masks
package ebcs_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] bus_address;
        logic        bus_write;
        logic [7:0]  bus_write_data;
        logic        instruction_done;
        logic        bad_opcode;
        logic [15:0] pc_value;
        logic [7:0]  acc_value;
        logic [3:0]  flag_bits;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_FETCH     = 3'd1,
        PH_FETCH_BAD = 3'd2,
        PH_RD1       = 3'd3,
        PH_RD2       = 3'd4,
        PH_WR1       = 3'd5,
        PH_WR2       = 3'd6
    } t_phase;

    localparam logic [3:0] FZ = 4'h8;
    localparam logic [3:0] FN = 4'h4;
    localparam logic [3:0] FH = 4'h2;
    localparam logic [3:0] FC = 4'h1;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

    localparam logic [7:0] OP_NOP = 8'h00, OP_INC_B = 8'h04, OP_DEC_B = 8'h05;
    localparam logic [7:0] OP_LD_B_N = 8'h06, OP_INC_C = 8'h0C, OP_DEC_C = 8'h0D;
    localparam logic [7:0] OP_LD_C_N = 8'h0E, OP_LD_DE_NN = 8'h11, OP_INC_DE = 8'h13;
    localparam logic [7:0] OP_DEC_D = 8'h15, OP_LD_D_N = 8'h16, OP_RLA = 8'h17;
    localparam logic [7:0] OP_JR = 8'h18, OP_LD_A_DE = 8'h1A, OP_DEC_E = 8'h1D;
    localparam logic [7:0] OP_LD_E_N = 8'h1E, OP_JR_NZ = 8'h20, OP_LD_HL_NN = 8'h21;
    localparam logic [7:0] OP_LDI_HL_A = 8'h22, OP_INC_HL = 8'h23, OP_INC_H = 8'h24;
    localparam logic [7:0] OP_JR_Z = 8'h28, OP_LD_L_N = 8'h2E, OP_LD_SP_NN = 8'h31;
    localparam logic [7:0] OP_LDD_HL_A = 8'h32, OP_DEC_A = 8'h3D, OP_LD_A_N = 8'h3E;
    localparam logic [7:0] OP_LD_C_A = 8'h4F, OP_LD_D_A = 8'h57, OP_LD_H_A = 8'h67;
    localparam logic [7:0] OP_LD_HL_A = 8'h77, OP_LD_A_B = 8'h78, OP_LD_A_E = 8'h7B;
    localparam logic [7:0] OP_LD_A_H = 8'h7C, OP_LD_A_L = 8'h7D, OP_ADD_HL = 8'h86;
    localparam logic [7:0] OP_SUB_B = 8'h90, OP_XOR_A = 8'hAF, OP_CP_HL = 8'hBE;
    localparam logic [7:0] OP_POP_BC = 8'hC1, OP_PUSH_BC = 8'hC5, OP_RET = 8'hC9;
    localparam logic [7:0] OP_PREFIX = 8'hCB, OP_CALL = 8'hCD, OP_LDH_N_A = 8'hE0;
    localparam logic [7:0] OP_LD_CI_A = 8'hE2, OP_LD_NN_A = 8'hEA, OP_LDH_A_N = 8'hF0;
    localparam logic [7:0] OP_CP_N = 8'hFE;
    localparam logic [7:0] CB_RL_C = 8'h11, CB_BIT7_H = 8'h7C;

endpackage

// ----- rtl/core/eight_bit_cpu_bus_sequencer.sv -----
// top level: sm83-style cpu subset run as a bus sequencer
// Each accepted input item (a start or write acknowledge, or returned read data) is decoded
// against the current micro phase and turned into exactly one result item: the next bus request
// with pc, accumulator and flags after the step. One item is taken per clock unless the input is
// stalled; the decode, the 8-bit alu and the 16-bit address adders sit between the input handshake
// and the result register, and a single result register with a skid register lets a new item in
// while a result waits. The first item after reset is taken as start and loads the pc from r_start.
module eight_bit_cpu_bus_sequencer import ebcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_start;
    t_phase      r_ph, n_ph;
    logic [7:0]  r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d, r_e, n_e, r_h, n_h, r_l, n_l;
    logic [3:0]  r_f, n_f;
    logic [15:0] r_sp, n_sp, r_pc, n_pc;
    logic [7:0]  r_opc, n_opc, r_lo, n_lo, r_hi, n_hi;
    logic        r_pre, n_pre;

    // output register plus skid register
    logic        r_ov, r_sv;
    t_out_item   r_out, r_skid, n_out;
    logic        acc_in;

    assign o_in_stall  = r_sv;
    assign acc_in      = i_in_valid && !r_sv;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // alu helpers
    function automatic logic [11:0] f_inc(input logic [7:0] v, input logic [3:0] f);
        logic [7:0] r;
        r = v + 8'd1;
        return {r, (r == 8'd0 ? FZ : 4'd0) | (r[3:0] == 4'd0 ? FH : 4'd0) | (f & FC)};
    endfunction

    function automatic logic [11:0] f_dec(input logic [7:0] v, input logic [3:0] f);
        logic [7:0] r;
        r = v - 8'd1;
        return {r, (r == 8'd0 ? FZ : 4'd0) | FN | (r[3:0] == 4'hF ? FH : 4'd0) | (f & FC)};
    endfunction

    function automatic logic [11:0] f_sub(input logic [7:0] a, input logic [7:0] v);
        logic [7:0] r;
        r = a - v;
        return {r, (r == 8'd0 ? FZ : 4'd0) | FN | (a[3:0] < v[3:0] ? FH : 4'd0)
                   | (a < v ? FC : 4'd0)};
    endfunction

    function automatic logic [11:0] f_rl(input logic [7:0] v, input logic [3:0] f,
                                         input logic zr);
        logic [7:0] r;
        r = {v[6:0], f[0]};
        return {r, ((zr && r == 8'd0) ? FZ : 4'd0) | (v[7] ? FC : 4'd0)};
    endfunction

    logic [11:0] w_alu;
    logic [8:0]  w_sum;
    logic [15:0] w_jr, w_ret, w_hl, w_de;

    // step logic
    always_comb begin
        logic [7:0] d;
        d = i_in_item.read_data;
        n_ph = r_ph; n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e; n_h = r_h;
        n_l = r_l; n_f = r_f; n_sp = r_sp; n_pc = r_pc; n_opc = r_opc; n_lo = r_lo;
        n_hi = r_hi; n_pre = r_pre;
        w_alu = 12'd0;
        w_sum = {1'b0, r_a} + {1'b0, d};
        w_jr = r_pc + 16'd2 + {{8{d[7]}}, d};
        w_hl = {r_h, r_l};
        w_de = {r_d, r_e};
        case (r_ph)
            PH_IDLE: begin
                n_pc = r_start; n_ph = PH_FETCH;
            end
            PH_WR1: if (!i_in_item.op) begin
                n_ph = PH_FETCH;
                case (r_opc)
                    OP_LDI_HL_A: begin {n_h, n_l} = w_hl + 16'd1; n_pc = r_pc + 16'd1; end
                    OP_LDD_HL_A: begin {n_h, n_l} = w_hl - 16'd1; n_pc = r_pc + 16'd1; end
                    OP_LDH_N_A:  n_pc = r_pc + 16'd2;
                    OP_LD_NN_A:  n_pc = r_pc + 16'd3;
                    OP_PUSH_BC, OP_CALL: n_ph = PH_WR2;
                    default:     n_pc = r_pc + 16'd1;
                endcase
            end
            PH_WR2: if (!i_in_item.op) begin
                n_sp = r_sp - 16'd2; n_ph = PH_FETCH;
                if (r_opc == OP_CALL) n_pc = {r_hi, r_lo};
                else n_pc = r_pc + 16'd1;
            end
            PH_RD1: if (i_in_item.op) begin
                n_ph = PH_FETCH;
                if (r_pre) begin
                    n_pre = 1'b0;
                    if (d == CB_RL_C) begin
                        w_alu = f_rl(r_c, r_f, 1'b1);
                        {n_c, n_f} = w_alu; n_pc = r_pc + 16'd2;
                    end else if (d == CB_BIT7_H) begin
                        n_f = (r_f & FC) | FH | (r_h[7] ? 4'd0 : FZ); n_pc = r_pc + 16'd2;
                    end else n_ph = PH_FETCH_BAD;
                end else begin
                    case (r_opc)
                        OP_LD_B_N: begin n_b = d; n_pc = r_pc + 16'd2; end
                        OP_LD_C_N: begin n_c = d; n_pc = r_pc + 16'd2; end
                        OP_LD_D_N: begin n_d = d; n_pc = r_pc + 16'd2; end
                        OP_LD_E_N: begin n_e = d; n_pc = r_pc + 16'd2; end
                        OP_LD_L_N: begin n_l = d; n_pc = r_pc + 16'd2; end
                        OP_LD_A_N: begin n_a = d; n_pc = r_pc + 16'd2; end
                        OP_JR:     n_pc = w_jr;
                        OP_JR_NZ:  n_pc = (r_f & FZ) != 4'd0 ? r_pc + 16'd2 : w_jr;
                        OP_JR_Z:   n_pc = (r_f & FZ) != 4'd0 ? w_jr : r_pc + 16'd2;
                        OP_CP_N: begin
                            w_alu = f_sub(r_a, d); n_f = w_alu[3:0]; n_pc = r_pc + 16'd2;
                        end
                        OP_LD_A_DE: begin n_a = d; n_pc = r_pc + 16'd1; end
                        OP_ADD_HL: begin
                            n_a = w_sum[7:0];
                            n_f = (w_sum[7:0] == 8'd0 ? FZ : 4'd0)
                                | ({1'b0, r_a[3:0]} + {1'b0, d[3:0]} > 5'd15 ? FH : 4'd0)
                                | (w_sum[8] ? FC : 4'd0);
                            n_pc = r_pc + 16'd1;
                        end
                        OP_CP_HL: begin
                            w_alu = f_sub(r_a, d); n_f = w_alu[3:0]; n_pc = r_pc + 16'd1;
                        end
                        OP_LDH_N_A: begin n_lo = d; n_ph = PH_WR1; end
                        default:    begin n_lo = d; n_ph = PH_RD2; end
                    endcase
                end
            end
            PH_RD2: if (i_in_item.op) begin
                n_ph = PH_FETCH;
                case (r_opc)
                    OP_LD_DE_NN: begin n_e = r_lo; n_d = d; n_pc = r_pc + 16'd3; end
                    OP_LD_HL_NN: begin n_l = r_lo; n_h = d; n_pc = r_pc + 16'd3; end
                    OP_LD_SP_NN: begin n_sp = {d, r_lo}; n_pc = r_pc + 16'd3; end
                    OP_LDH_A_N:  begin n_a = d; n_pc = r_pc + 16'd2; end
                    OP_POP_BC: begin
                        n_c = r_lo; n_b = d; n_sp = r_sp + 16'd2; n_pc = r_pc + 16'd1;
                    end
                    OP_RET: begin n_pc = {d, r_lo}; n_sp = r_sp + 16'd2; end
                    default: begin n_hi = d; n_ph = PH_WR1; end
                endcase
            end
            default: if (i_in_item.op) begin
                // opcode fetch
                n_opc = d; n_pre = 1'b0; n_ph = PH_FETCH;
                case (d)
                    OP_NOP:    n_pc = r_pc + 16'd1;
                    OP_INC_B:  begin w_alu = f_inc(r_b, r_f); {n_b, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_DEC_B:  begin w_alu = f_dec(r_b, r_f); {n_b, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_INC_C:  begin w_alu = f_inc(r_c, r_f); {n_c, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_DEC_C:  begin w_alu = f_dec(r_c, r_f); {n_c, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_INC_DE: begin {n_d, n_e} = w_de + 16'd1; n_pc = r_pc + 16'd1; end
                    OP_DEC_D:  begin w_alu = f_dec(r_d, r_f); {n_d, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_RLA:    begin w_alu = f_rl(r_a, r_f, 1'b0); {n_a, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_DEC_E:  begin w_alu = f_dec(r_e, r_f); {n_e, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_INC_HL: begin {n_h, n_l} = w_hl + 16'd1; n_pc = r_pc + 16'd1; end
                    OP_INC_H:  begin w_alu = f_inc(r_h, r_f); {n_h, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_DEC_A:  begin w_alu = f_dec(r_a, r_f); {n_a, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_LD_C_A: begin n_c = r_a; n_pc = r_pc + 16'd1; end
                    OP_LD_D_A: begin n_d = r_a; n_pc = r_pc + 16'd1; end
                    OP_LD_H_A: begin n_h = r_a; n_pc = r_pc + 16'd1; end
                    OP_LD_A_B: begin n_a = r_b; n_pc = r_pc + 16'd1; end
                    OP_LD_A_E: begin n_a = r_e; n_pc = r_pc + 16'd1; end
                    OP_LD_A_H: begin n_a = r_h; n_pc = r_pc + 16'd1; end
                    OP_LD_A_L: begin n_a = r_l; n_pc = r_pc + 16'd1; end
                    OP_SUB_B:  begin w_alu = f_sub(r_a, r_b); {n_a, n_f} = w_alu;
                                     n_pc = r_pc + 16'd1; end
                    OP_XOR_A:  begin n_a = 8'd0; n_f = FZ; n_pc = r_pc + 16'd1; end
                    OP_LD_B_N, OP_LD_C_N, OP_LD_DE_NN, OP_LD_D_N, OP_JR, OP_LD_A_DE,
                    OP_LD_E_N, OP_JR_NZ, OP_LD_HL_NN, OP_JR_Z, OP_LD_L_N, OP_LD_SP_NN,
                    OP_LD_A_N, OP_ADD_HL, OP_CP_HL, OP_POP_BC, OP_RET, OP_CALL,
                    OP_LDH_N_A, OP_LD_NN_A, OP_LDH_A_N, OP_CP_N:
                        n_ph = PH_RD1;
                    OP_PREFIX: begin n_pre = 1'b1; n_ph = PH_RD1; end
                    OP_LDI_HL_A, OP_LDD_HL_A, OP_LD_HL_A, OP_PUSH_BC, OP_LD_CI_A:
                        n_ph = PH_WR1;
                    default: n_ph = PH_FETCH_BAD;
                endcase
            end
        endcase
    end

    // result item from the state after the step
    always_comb begin
        w_ret = n_pc + 16'd3;
        n_out = '0;
        n_out.bus_address = n_pc;
        n_out.pc_value = n_pc;
        n_out.acc_value = n_a;
        n_out.flag_bits = n_f;
        case (n_ph)
            PH_RD1: begin
                if (n_pre) n_out.bus_address = n_pc + 16'd1;
                else if (n_opc == OP_LD_A_DE) n_out.bus_address = {n_d, n_e};
                else if (n_opc == OP_ADD_HL || n_opc == OP_CP_HL)
                    n_out.bus_address = {n_h, n_l};
                else if (n_opc == OP_POP_BC || n_opc == OP_RET) n_out.bus_address = n_sp;
                else n_out.bus_address = n_pc + 16'd1;
            end
            PH_RD2: begin
                if (n_opc == OP_LDH_A_N) n_out.bus_address = HIGH_PAGE | {8'd0, n_lo};
                else if (n_opc == OP_POP_BC || n_opc == OP_RET)
                    n_out.bus_address = n_sp + 16'd1;
                else n_out.bus_address = n_pc + 16'd2;
            end
            PH_WR1: begin
                n_out.bus_write = 1'b1;
                n_out.bus_write_data = n_a;
                if (n_opc == OP_LDH_N_A) n_out.bus_address = HIGH_PAGE | {8'd0, n_lo};
                else if (n_opc == OP_LD_CI_A) n_out.bus_address = HIGH_PAGE | {8'd0, n_c};
                else if (n_opc == OP_LD_NN_A) n_out.bus_address = {n_hi, n_lo};
                else if (n_opc == OP_PUSH_BC) begin
                    n_out.bus_address = n_sp - 16'd1; n_out.bus_write_data = n_b;
                end else if (n_opc == OP_CALL) begin
                    n_out.bus_address = n_sp - 16'd1; n_out.bus_write_data = w_ret[15:8];
                end else n_out.bus_address = {n_h, n_l};
            end
            PH_WR2: begin
                n_out.bus_write = 1'b1;
                n_out.bus_address = n_sp - 16'd2;
                n_out.bus_write_data = (n_opc == OP_PUSH_BC) ? n_c : w_ret[7:0];
            end
            PH_FETCH_BAD: begin
                n_out.bad_opcode = 1'b1; n_out.instruction_done = 1'b1;
            end
            default: n_out.instruction_done = 1'b1;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 16'd0; r_ph <= PH_IDLE;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_e <= '0; r_h <= '0; r_l <= '0;
            r_f <= '0; r_sp <= '0; r_pc <= '0; r_opc <= '0; r_lo <= '0; r_hi <= '0;
            r_pre <= 1'b0;
        end else begin
            if (i_cfg_valid) r_start <= i_cfg_data;
            if (acc_in) begin
                r_ph <= n_ph; r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d; r_e <= n_e;
                r_h <= n_h; r_l <= n_l; r_f <= n_f; r_sp <= n_sp; r_pc <= n_pc;
                r_opc <= n_opc; r_lo <= n_lo; r_hi <= n_hi; r_pre <= n_pre;
            end
        end
    end

    // output and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_sv <= 1'b0;
        end else begin
            if (!r_ov || !i_out_stall) begin
                r_ov <= r_sv || acc_in;
                r_sv <= 1'b0;
            end else if (acc_in) begin
                r_sv <= 1'b1;
            end
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_out_stall) begin
            r_out <= r_sv ? r_skid : n_out;
        end else if (acc_in) begin
            r_skid <= n_out;
        end
    end

    // a result never gets lost while the skid stage is full
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_sv |-> r_ov)
        else $error("skid full without output valid");
    // a write request always comes from a write phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && n_out.bus_write) |-> (n_ph == PH_WR1 || n_ph == PH_WR2))
        else $error("write request outside write phase");
    // accepted item always leaves the idle phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> r_ph != PH_IDLE)
        else $error("idle after accepted item");

endmodule
